FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks that expect clk and rst_n in scope
`ifndef ASSERT_OFF
`define BIM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("broadcast index mapper check failed");
`define BIM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("broadcast index mapper reset check failed");
`else
`define BIM_ASSERT(lbl, prop)
`define BIM_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: src/bim_pkg.sv
package bim_pkg;

  localparam int IDX_W      = 32;
  localparam int OFF_W      = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_REGS    = 4;
  localparam int CNT_W      = 33;

  localparam logic [CFG_W-1:0] DIMS_RESET   = 64'h0001_0001_0001_0001;
  localparam logic [2:0]       RANK_RESET   = 3'd1;
  localparam logic [2:0]       NUM_IN_RESET = 3'd2;
  localparam logic [CNT_W-1:0] CNT_LIMIT    = 33'h0_FFFF_FFFF;
  localparam logic [CNT_W-1:0] CNT_SAT      = 33'h1_0000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OUT_DIMS   = 3'd0,
    REG_IN0_DIMS   = 3'd1,
    REG_IN1_DIMS   = 3'd2,
    REG_IN2_DIMS   = 3'd3,
    REG_IN3_DIMS   = 3'd4,
    REG_RANK       = 3'd5,
    REG_NUM_INPUTS = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset0;
    logic [OFF_W-1:0] offset1;
    logic [OFF_W-1:0] offset2;
    logic [OFF_W-1:0] offset3;
    logic             index_in_range;
    logic             size_overflow;
  } out_item_t;

endpackage

FILE: src/bim_stream_if.sv
interface bim_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/bim_div_cell.sv
module bim_div_cell #(
  parameter int Q_W = 32,
  parameter int R_W = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [Q_W-1:0] q_i,
  input  logic [R_W-1:0] rem_i,
  input  logic [R_W-1:0] div_i,
  output logic [Q_W-1:0] q_o,
  output logic [R_W-1:0] rem_o
);
  logic [R_W:0]   sh;
  logic [R_W:0]   diff;
  logic           ge;
  logic [Q_W-1:0] q_r;
  logic [R_W-1:0] rem_r;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign sh   = {rem_i, q_i[Q_W-1]};
  assign diff = sh - {1'b0, div_i};
  assign ge   = (sh >= {1'b0, div_i});

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= {q_i[Q_W-2:0], ge};
      rem_r <= ge ? diff[R_W-1:0] : sh[R_W-1:0];
    end
  end

  assign q_o   = q_r;
  assign rem_o = rem_r;
endmodule

FILE: src/bim_split.sv
module bim_split #(
  parameter int MAX_DIMS = 4,
  parameter int DIM_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  logic [bim_pkg::IDX_W-1:0]           idx_i,
  input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]   dim_i,
  input  logic [3:0]                          nd_i,
  output logic                                vld_o,
  output logic [MAX_DIMS-1:0][DIM_BITS-1:0]   coord_o,
  output logic                                inr_o
);
  import bim_pkg::*;

  localparam int NS = IDX_W * MAX_DIMS;

  typedef logic [MAX_DIMS-1:0][DIM_BITS-1:0] coord_t;

  logic [IDX_W-1:0]    q_w   [NS];
  logic [DIM_BITS-1:0] rem_w [NS];
  logic [NS-1:0]       vld_r;
  logic [NS-1:0]       flag_r;
  coord_t              coord_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int DI = s / IDX_W;
    localparam int ST = s % IDX_W;

    logic [IDX_W-1:0]    q_in;
    logic [DIM_BITS-1:0] rem_in;
    coord_t              coord_nxt;
    logic                flag_nxt;
    logic                vld_nxt;

    if (s == 0) begin : g_first
      assign q_in      = idx_i;
      assign rem_in    = '0;
      assign coord_nxt = '0;
      assign flag_nxt  = 1'b0;
      assign vld_nxt   = vld_i;
    end else if (ST == 0) begin : g_dim_start
      // previous dimension finished: latch its remainder as a coordinate
      assign q_in    = q_w[s-1];
      assign rem_in  = '0;
      assign vld_nxt = vld_r[s-1];
      always_comb begin
        coord_nxt       = coord_r[s-1];
        coord_nxt[DI-1] = rem_w[s-1];
      end
      assign flag_nxt = (nd_i == 4'(DI)) ? (q_w[s-1] == '0) : flag_r[s-1];
    end else begin : g_mid
      assign q_in      = q_w[s-1];
      assign rem_in    = rem_w[s-1];
      assign coord_nxt = coord_r[s-1];
      assign flag_nxt  = flag_r[s-1];
      assign vld_nxt   = vld_r[s-1];
    end

    bim_div_cell #(
      .Q_W (IDX_W),
      .R_W (DIM_BITS)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .q_i   (q_in),
      .rem_i (rem_in),
      .div_i (dim_i[DI]),
      .q_o   (q_w[s]),
      .rem_o (rem_w[s])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        coord_r[s] <= coord_nxt;
        flag_r[s]  <= flag_nxt;
      end
    end
  end

  assign vld_o = vld_r[NS-1];

  always_comb begin
    coord_o             = coord_r[NS-1];
    coord_o[MAX_DIMS-1] = rem_w[NS-1];
  end

  // index is in range when the quotient past the last used dimension is zero
  assign inr_o = (nd_i == 4'(MAX_DIMS)) ? (q_w[NS-1] == '0) : flag_r[NS-1];
endmodule

FILE: src/bim_mod.sv
module bim_mod #(
  parameter int MAX_DIMS = 4,
  parameter int DIM_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   vld_i,
  input  logic                                                   inr_i,
  input  logic [MAX_DIMS-1:0][DIM_BITS-1:0]                      coord_i,
  input  logic [bim_pkg::IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] dim_i,
  output logic                                                   vld_o,
  output logic                                                   inr_o,
  output logic [bim_pkg::IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] mod_o
);
  import bim_pkg::*;

  logic [DIM_BITS-1:0] q_w   [IN_REGS][MAX_DIMS][DIM_BITS];
  logic [DIM_BITS-1:0] rem_w [IN_REGS][MAX_DIMS][DIM_BITS];
  logic [DIM_BITS-1:0] vld_r;
  logic [DIM_BITS-1:0] inr_r;

  for (genvar k = 0; k < IN_REGS; k++) begin : g_in
    for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
      for (genvar st = 0; st < DIM_BITS; st++) begin : g_step
        logic [DIM_BITS-1:0] q_in;
        logic [DIM_BITS-1:0] rem_in;

        if (st == 0) begin : g_first
          assign q_in   = coord_i[i];
          assign rem_in = '0;
        end else begin : g_next
          assign q_in   = q_w[k][i][st-1];
          assign rem_in = rem_w[k][i][st-1];
        end

        bim_div_cell #(
          .Q_W (DIM_BITS),
          .R_W (DIM_BITS)
        ) u_cell (
          .clk   (clk),
          .en    (en),
          .q_i   (q_in),
          .rem_i (rem_in),
          .div_i (dim_i[k][i]),
          .q_o   (q_w[k][i][st]),
          .rem_o (rem_w[k][i][st])
        );
      end
      assign mod_o[k][i] = rem_w[k][i][DIM_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIM_BITS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr_r <= {inr_r[DIM_BITS-2:0], inr_i};
    end
  end

  assign vld_o = vld_r[DIM_BITS-1];
  assign inr_o = inr_r[DIM_BITS-1];
endmodule

FILE: src/bim_comb.sv
module bim_comb #(
  parameter int MAX_DIMS = 4,
  parameter int DIM_BITS = 16
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   en,
  input  logic                                                   vld_i,
  input  logic                                                   inr_i,
  input  logic [bim_pkg::IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] mod_i,
  input  logic [bim_pkg::IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] dim_i,
  input  logic [3:0]                                             nd_i,
  output logic                                                   vld_o,
  output logic                                                   inr_o,
  output logic [bim_pkg::IN_REGS-1:0][bim_pkg::OFF_W-1:0]         off_o
);
  import bim_pkg::*;

  typedef logic [IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] mod_t;
  typedef logic [IN_REGS-1:0][OFF_W-1:0]                  off_t;

  logic [MAX_DIMS-1:0] vld_r;
  logic [MAX_DIMS-1:0] inr_r;
  off_t                off_r [MAX_DIMS];
  mod_t                mod_w [MAX_DIMS];

  // outermost dimension first: off = off * size + (coordinate mod size), for used dimensions only
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_stage
    localparam int DI = MAX_DIMS - 1 - j;

    off_t off_in;
    off_t off_nxt;
    logic vld_in;
    logic inr_in;

    if (j == 0) begin : g_first
      assign off_in = '0;
      assign vld_in = vld_i;
      assign inr_in = inr_i;
      assign mod_w[j] = mod_i;
    end else begin : g_next
      assign off_in = off_r[j-1];
      assign vld_in = vld_r[j-1];
      assign inr_in = inr_r[j-1];
    end

    if (j < MAX_DIMS - 1) begin : g_carry
      mod_t mod_r;
      always_ff @(posedge clk) begin
        if (en) begin
          mod_r <= mod_w[j];
        end
      end
      assign mod_w[j+1] = mod_r;
    end

    for (genvar k = 0; k < IN_REGS; k++) begin : g_in
      logic [OFF_W+DIM_BITS-1:0] prod;
      assign prod = off_in[k] * dim_i[k][DI];
      assign off_nxt[k] = (nd_i > 4'(DI))
                        ? (prod[OFF_W-1:0] + OFF_W'(mod_w[j][k][DI]))
                        : off_in[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        off_r[j] <= off_nxt;
        inr_r[j] <= inr_in;
      end
    end
  end

  assign vld_o = vld_r[MAX_DIMS-1];
  assign inr_o = inr_r[MAX_DIMS-1];
  assign off_o = off_r[MAX_DIMS-1];
endmodule

FILE: src/broadcast_index_mapper_top.sv
// throughput: one request per cycle; the whole cell chain stalls while a result waits
// latency comes from the bit-serial divider cells, one quotient bit per cell, and the combine stages
// reset: synchronous active-low rst_n empties the chain and loads all sizes with one,
// rank with one and the input count with two
`include "assert_macros.svh"

module broadcast_index_mapper_top #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_INPUTS = 4,
  parameter int DIM_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bim_stream_if.sink                         in_ch,
  bim_stream_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [bim_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bim_pkg::CFG_W-1:0]          cfg_wdata
);
  import bim_pkg::*;

  localparam int NI_MAX = (MAX_INPUTS < IN_REGS) ? MAX_INPUTS : IN_REGS;
  localparam int NT     = IN_REGS + 1;
  localparam int PW     = CNT_W + DIM_BITS;

  typedef logic [MAX_DIMS-1:0][DIM_BITS-1:0] dims_t;

  logic [CFG_W-1:0] out_dims_r;
  logic [CFG_W-1:0] in_dims_r [IN_REGS];
  logic [2:0]       rank_r;
  logic [2:0]       num_in_r;

  dims_t                     tdim [NT];
  dims_t                     tdim_nz [NT];
  logic [IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] in_dim;
  logic [IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] in_dim_nz;
  logic [3:0]                nd;
  logic [2:0]                ni;
  logic                      en;

  logic                      sp_vld;
  logic                      sp_inr;
  dims_t                     sp_coord;
  logic                      md_vld;
  logic                      md_inr;
  logic [IN_REGS-1:0][MAX_DIMS-1:0][DIM_BITS-1:0] md_mod;
  logic                      cb_vld;
  logic                      cb_inr;
  logic [IN_REGS-1:0][OFF_W-1:0] cb_off;
  logic [IN_REGS-1:0][OFF_W-1:0] off_m;

  logic [CNT_W-1:0]          cnt_r [MAX_DIMS][NT];
  logic [NT-1:0]             over;
  logic                      ovf_r;
  logic [MAX_DIMS-1:0]       zero_dim;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_dims_r <= DIMS_RESET;
      for (int k = 0; k < IN_REGS; k++) begin
        in_dims_r[k] <= DIMS_RESET;
      end
      rank_r   <= RANK_RESET;
      num_in_r <= NUM_IN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_OUT_DIMS:   out_dims_r   <= cfg_wdata;
        REG_IN0_DIMS:   in_dims_r[0] <= cfg_wdata;
        REG_IN1_DIMS:   in_dims_r[1] <= cfg_wdata;
        REG_IN2_DIMS:   in_dims_r[2] <= cfg_wdata;
        REG_IN3_DIMS:   in_dims_r[3] <= cfg_wdata;
        REG_RANK:       rank_r       <= cfg_wdata[2:0];
        REG_NUM_INPUTS: num_in_r     <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign nd = (rank_r == 3'd0) ? 4'd1
            : ({1'b0, rank_r} > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : {1'b0, rank_r};
  assign ni = (num_in_r < 3'd2) ? 3'd2
            : (num_in_r > 3'(NI_MAX)) ? 3'(NI_MAX) : num_in_r;

  // size fields; a field starting past the register reads as one
  for (genvar t = 0; t < NT; t++) begin : g_tensor
    logic [CFG_W+DIM_BITS-1:0] padded;
    if (t == 0) begin : g_out
      assign padded = {{DIM_BITS{1'b0}}, out_dims_r};
    end else begin : g_in
      assign padded = {{DIM_BITS{1'b0}}, in_dims_r[t-1]};
      assign in_dim[t-1]    = tdim[t];
      assign in_dim_nz[t-1] = tdim_nz[t];
    end
    for (genvar i = 0; i < MAX_DIMS; i++) begin : g_dim
      if (i * DIM_BITS >= CFG_W) begin : g_beyond
        assign tdim[t][i] = DIM_BITS'(1);
      end else begin : g_field
        assign tdim[t][i] = padded[i*DIM_BITS +: DIM_BITS];
      end
      assign tdim_nz[t][i] = (tdim[t][i] == '0) ? DIM_BITS'(1) : tdim[t][i];
    end
  end

  // element counts, recomputed every cycle from the stable registers
  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_cnt
    for (genvar t = 0; t < NT; t++) begin : g_t
      logic [CNT_W-1:0]    prev;
      logic [DIM_BITS-1:0] fac;
      logic [PW-1:0]       prod;
      if (j == 0) begin : g_first
        assign prev = CNT_W'(1);
      end else begin : g_next
        assign prev = cnt_r[j-1][t];
      end
      assign fac  = (nd > 4'(j)) ? tdim[t][j] : DIM_BITS'(1);
      assign prod = prev * fac;
      always_ff @(posedge clk) begin
        cnt_r[j][t] <= (prod > PW'(CNT_LIMIT)) ? CNT_SAT : prod[CNT_W-1:0];
      end
    end
  end

  for (genvar t = 0; t < NT; t++) begin : g_over
    if (t == 0) begin : g_out
      assign over[t] = cnt_r[MAX_DIMS-1][t][CNT_W-1];
    end else begin : g_in
      assign over[t] = cnt_r[MAX_DIMS-1][t][CNT_W-1] && (ni > 3'(t-1));
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= |over;
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_zero
    assign zero_dim[i] = (tdim[0][i] == '0) && (nd > 4'(i));
  end

  assign en          = !cb_vld || out_ch.ready;
  assign in_ch.ready = en;

  bim_split #(
    .MAX_DIMS (MAX_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_ch.valid),
    .idx_i   (in_ch.data.out_index),
    .dim_i   (tdim_nz[0]),
    .nd_i    (nd),
    .vld_o   (sp_vld),
    .coord_o (sp_coord),
    .inr_o   (sp_inr)
  );

  bim_mod #(
    .MAX_DIMS (MAX_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sp_vld),
    .inr_i   (sp_inr),
    .coord_i (sp_coord),
    .dim_i   (in_dim_nz),
    .vld_o   (md_vld),
    .inr_o   (md_inr),
    .mod_o   (md_mod)
  );

  bim_comb #(
    .MAX_DIMS (MAX_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_comb (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (md_vld),
    .inr_i (md_inr),
    .mod_i (md_mod),
    .dim_i (in_dim),
    .nd_i  (nd),
    .vld_o (cb_vld),
    .inr_o (cb_inr),
    .off_o (cb_off)
  );

  for (genvar k = 0; k < IN_REGS; k++) begin : g_mask
    assign off_m[k] = (ni > 3'(k)) ? cb_off[k] : '0;
  end

  assign out_ch.valid               = cb_vld;
  assign out_ch.data.offset0        = off_m[0];
  assign out_ch.data.offset1        = off_m[1];
  assign out_ch.data.offset2        = off_m[2];
  assign out_ch.data.offset3        = off_m[3];
  assign out_ch.data.index_in_range = cb_inr && !(|zero_dim);
  assign out_ch.data.size_overflow  = ovf_r;

  `BIM_ASSERT_RST(a_reset_empties, !rst_n |=> !out_ch.valid)
  `BIM_ASSERT(a_unused_input_zero, out_ch.valid && ni == 3'd2 |-> out_ch.data.offset2 == '0)
  `BIM_ASSERT(a_rank1_offset_bound, out_ch.valid && nd == 4'd1 && in_dim[0][0] != '0 |-> out_ch.data.offset0 < OFF_W'(in_dim[0][0]))
endmodule

FILE: dv/tb_broadcast_index_mapper_top.sv
`timescale 1ns / 100ps

module tb_broadcast_index_mapper_top;
  import bim_pkg::*;

  localparam int LATENCY    = 32 * 4 + 16 + 4;
  localparam int STALL_MAX  = 4000;
  localparam int PHASE_REQS = 140;
  localparam int NUM_PHASES = 12;

  typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    cfg_reg_t   addr;
    logic [63:0] value;
    bit         known;
    out_item_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  bim_stream_if #(.T(in_item_t))  in_ch ();
  bim_stream_if #(.T(out_item_t)) out_ch ();

  broadcast_index_mapper_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the mapper registers
  logic [63:0] shadow_out_dims;
  logic [63:0] shadow_in_dims [4];
  logic [2:0]  shadow_rank;
  logic [2:0]  shadow_num_in;

  out_item_t   expected_maps [$];
  stim_row_t   directed_rows [$];
  int          errors;
  int          reqs_sent;
  int          maps_checked;
  int          overflow_maps;
  int          out_of_range_maps;
  int          idle_cycles;
  int          idle_mode;
  bit          use_known;
  out_item_t   known_res;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint unsigned elem_count(logic [63:0] dims, int nd);
    longint unsigned prod;
    prod = 1;
    for (int i = 0; i < nd; i++) begin
      prod = prod * dims[i*16 +: 16];
      if (prod > 64'hFFFF_FFFF) prod = 64'h1_0000_0000;
    end
    return prod;
  endfunction

  function automatic int used_dims();
    return (shadow_rank == 0) ? 1 : ((shadow_rank > 4) ? 4 : int'(shadow_rank));
  endfunction

  function automatic out_item_t predict_map(logic [31:0] out_index);
    longint unsigned rem, d, dm, off, ocnt;
    longint unsigned coord [4];
    int nd, ni;
    bit ovf;
    out_item_t r;
    nd = used_dims();
    ni = (shadow_num_in < 2) ? 2 : ((shadow_num_in > 4) ? 4 : int'(shadow_num_in));
    ocnt = elem_count(shadow_out_dims, nd);
    ovf = ocnt > 64'hFFFF_FFFF;
    rem = out_index;
    for (int i = 0; i < nd; i++) begin
      d = shadow_out_dims[i*16 +: 16];
      if (d == 0) d = 1;
      coord[i] = rem % d;
      rem = rem / d;
    end
    r = '0;
    for (int k = 0; k < ni; k++) begin
      off = 0;
      if (elem_count(shadow_in_dims[k], nd) > 64'hFFFF_FFFF) ovf = 1'b1;
      for (int i = nd - 1; i >= 0; i--) begin
        d = shadow_in_dims[k][i*16 +: 16];
        dm = (d == 0) ? 1 : d;
        off = (off * d + coord[i] % dm) & 64'hFFFF_FFFF;
      end
      case (k)
        0: r.offset0 = off[31:0];
        1: r.offset1 = off[31:0];
        2: r.offset2 = off[31:0];
        default: r.offset3 = off[31:0];
      endcase
    end
    r.index_in_range = (longint'(out_index) < ocnt);
    r.size_overflow = ovf;
    return r;
  endfunction

  // scoreboard: requests in, mapped offsets out
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (use_known) begin
          expected_maps.push_back(known_res);
          use_known = 1'b0;
        end else begin
          expected_maps.push_back(predict_map(in_ch.data.out_index));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_maps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, out_ch.data);
        end else begin
          out_item_t e;
          out_item_t a;
          e = expected_maps.pop_front();
          a = out_ch.data;
          maps_checked++;
          if (a.size_overflow) overflow_maps++;
          if (!a.index_in_range) out_of_range_maps++;
          if (a.offset0 !== e.offset0) begin
            errors++;
            $display("%0t: offset0 expected %h actual %h", $time, e.offset0, a.offset0);
          end
          if (a.offset1 !== e.offset1) begin
            errors++;
            $display("%0t: offset1 expected %h actual %h", $time, e.offset1, a.offset1);
          end
          if (a.offset2 !== e.offset2) begin
            errors++;
            $display("%0t: offset2 expected %h actual %h", $time, e.offset2, a.offset2);
          end
          if (a.offset3 !== e.offset3) begin
            errors++;
            $display("%0t: offset3 expected %h actual %h", $time, e.offset3, a.offset3);
          end
          if (a.index_in_range !== e.index_in_range) begin
            errors++;
            $display("%0t: index_in_range expected %b actual %b", $time,
                     e.index_in_range, a.index_in_range);
          end
          if (a.size_overflow !== e.size_overflow) begin
            errors++;
            $display("%0t: size_overflow expected %b actual %b", $time,
                     e.size_overflow, a.size_overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("broadcast_index_mapper_top verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    case (idle_mode)
      0: out_ch.ready = ($urandom_range(99) >= 64);
      1: out_ch.ready = ($urandom_range(99) >= 14);
      default: out_ch.ready = 1'b1;
    endcase
  end

  task automatic send_req(logic [31:0] out_index);
    int gap_pct;
    idle_mode = (reqs_sent < 580) ? 0 : ((reqs_sent < 1160) ? 1 : 2);
    gap_pct = (idle_mode == 0) ? 14 : ((idle_mode == 1) ? 64 : 0);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data.out_index = out_index;
    do @(posedge clk); while (!in_ch.ready);
    reqs_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (expected_maps.size() == 0);
  endtask

  // only called with nothing in flight
  task automatic write_reg(cfg_reg_t addr, logic [63:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = value;
    case (addr)
      REG_OUT_DIMS:   shadow_out_dims = value;
      REG_IN0_DIMS:   shadow_in_dims[0] = value;
      REG_IN1_DIMS:   shadow_in_dims[1] = value;
      REG_IN2_DIMS:   shadow_in_dims[2] = value;
      REG_IN3_DIMS:   shadow_in_dims[3] = value;
      REG_RANK:       shadow_rank = value[2:0];
      REG_NUM_INPUTS: shadow_num_in = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic add_cfg(cfg_reg_t addr, logic [63:0] value);
    stim_row_t row;
    row = '{kind: ROW_CFG, addr: addr, value: value, known: 1'b0, res: '0};
    directed_rows.push_back(row);
  endtask

  task automatic add_req(logic [31:0] out_index, bit known, out_item_t res);
    stim_row_t row;
    row = '{kind: ROW_REQ, addr: REG_OUT_DIMS, value: 64'(out_index), known: known,
            res: res};
    directed_rows.push_back(row);
  endtask

  function automatic logic [15:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'h0;
    if (r < 14) return 16'hFFFF;
    if (r < 20) return 16'($urandom);
    return 16'($urandom_range(1, 9));
  endfunction

  function automatic logic [31:0] rand_index();
    longint unsigned c;
    int r;
    c = elem_count(shadow_out_dims, used_dims());
    r = $urandom_range(99);
    if (c > 0 && c <= 64'hFFFF_FFFF) begin
      if (r < 70) return 32'($urandom_range(0, 32'(c - 1)));
      if (r < 80) return (r < 75) ? 32'(c - 1) : 32'(c);
    end
    return $urandom;
  endfunction

  task automatic random_config();
    logic [63:0] od, id;
    int r;
    for (int i = 0; i < 4; i++) od[i*16 +: 16] = rand_size();
    write_reg(REG_OUT_DIMS, od);
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++) begin
        r = $urandom_range(99);
        id[i*16 +: 16] = (r < 45) ? od[i*16 +: 16] : ((r < 80) ? 16'd1 : rand_size());
      end
      write_reg(cfg_reg_t'(REG_IN0_DIMS + k), id);
    end
    write_reg(REG_RANK, ({$urandom, $urandom} & ~64'h7) | 64'($urandom_range(0, 7)));
    write_reg(REG_NUM_INPUTS, ({$urandom, $urandom} & ~64'h7) | 64'($urandom_range(0, 7)));
  endtask

  initial begin
    out_item_t z;
    errors = 0;
    reqs_sent = 0;
    maps_checked = 0;
    overflow_maps = 0;
    out_of_range_maps = 0;
    idle_cycles = 0;
    idle_mode = 0;
    use_known = 1'b0;
    known_res = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    shadow_out_dims = DIMS_RESET;
    for (int k = 0; k < 4; k++) shadow_in_dims[k] = DIMS_RESET;
    shadow_rank = RANK_RESET;
    shadow_num_in = NUM_IN_RESET;

    // reset shape is a single element: only index zero is in range
    z = '0;
    z.index_in_range = 1'b1;
    add_req(32'h0, 1'b1, z);
    z.index_in_range = 1'b0;
    add_req(32'h1, 1'b1, z);
    add_req(32'hFFFF_FFFF, 1'b1, z);
    // 5x2x3x4 with broadcasting inputs, rank and count above their maximum
    add_cfg(REG_OUT_DIMS, 64'h0004_0003_0002_0005);
    add_cfg(REG_IN0_DIMS, 64'h0004_0003_0002_0005);
    add_cfg(REG_IN1_DIMS, 64'h0001_0003_0001_0005);
    add_cfg(REG_IN2_DIMS, 64'h0004_0001_0002_0001);
    add_cfg(REG_IN3_DIMS, 64'h0001_0001_0001_0001);
    add_cfg(REG_RANK, 64'h7);
    add_cfg(REG_NUM_INPUTS, 64'h7);
    add_req(32'd0, 1'b0, z);
    add_req(32'd7, 1'b0, z);
    add_req(32'd119, 1'b0, z);
    add_req(32'd120, 1'b0, z);
    add_req(32'hFFFF_FFFF, 1'b0, z);
    // rank and count below their minimum
    add_cfg(REG_RANK, 64'h0);
    add_cfg(REG_NUM_INPUTS, 64'h0);
    add_req(32'd4, 1'b0, z);
    add_req(32'd5, 1'b0, z);
    // zero-size dimensions
    add_cfg(REG_OUT_DIMS, 64'h0000_0003_0000_0002);
    add_cfg(REG_RANK, 64'h4);
    add_req(32'd6, 1'b0, z);
    add_req(32'd0, 1'b0, z);
    // every size at its maximum: element counts overflow
    add_cfg(REG_OUT_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_IN0_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_IN1_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_IN2_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_IN3_DIMS, 64'hFFFF_FFFF_FFFF_FFFF);
    add_cfg(REG_NUM_INPUTS, 64'hFFFF_FFFF_FFFF_FFFC);
    add_req(32'h1234_5678, 1'b0, z);
    add_req(32'hFFFF_FFFF, 1'b0, z);
    add_req(32'h0, 1'b0, z);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[j]) begin
      if (directed_rows[j].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[j].addr, directed_rows[j].value);
      end else begin
        // typed-in rows replace the predicted value for the next request
        if (directed_rows[j].known) begin
          @(negedge clk);
          in_ch.valid = 1'b0;
          known_res = directed_rows[j].res;
          use_known = 1'b1;
        end
        send_req(directed_rows[j].value[31:0]);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == 0) begin
        for (int k = 0; k < 5; k++) write_reg(cfg_reg_t'(REG_OUT_DIMS + k), 64'h0);
        write_reg(REG_RANK, 64'h4);
        write_reg(REG_NUM_INPUTS, 64'h4);
      end else begin
        random_config();
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (p == 4 && n == PHASE_REQS / 2) drain();
        send_req(rand_index());
      end
    end

    drain();
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d index requests over %0d shape settings, checked %0d results",
             reqs_sent, NUM_PHASES + 5, maps_checked);
    $display("%0d results out of range, %0d with size overflow", out_of_range_maps,
             overflow_maps);
    if (errors == 0 && expected_maps.size() == 0) begin
      $display("broadcast_index_mapper_top verification clean");
    end else begin
      $display("broadcast_index_mapper_top verification failed");
    end
    $finish;
  end

endmodule
